/* hdl/deq_pkg.sv */
// Shared constants, codes and controller command type for the deque unit.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int OP_W       = 3;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = OP_W'(0);
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_POP_FRONT  = OP_W'(2);
    localparam logic [OP_W-1:0] OP_POP_BACK   = OP_W'(3);
    localparam logic [OP_W-1:0] OP_QUERY      = OP_W'(4);

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic read;
        logic load;
    } deq_cmd_t;

endpackage

`default_nettype wire

/* hdl/deq_datapath.sv */
// Deque datapath: word memory, head pointer, count, read and result registers.
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire deq_pkg::deq_cmd_t                   cmd,
    input  wire logic [deq_pkg::OP_W-1:0]            op,
    input  wire logic signed [deq_pkg::DATA_WIDTH-1:0] data_value,
    output logic signed [deq_pkg::DATA_WIDTH-1:0]    front_value,
    output logic signed [deq_pkg::DATA_WIDTH-1:0]    back_value,
    output logic [deq_pkg::CNT_W-1:0]                occupancy,
    output logic                                     is_empty,
    output logic                                     is_full,
    output logic [1:0]                               status
);

    logic [deq_pkg::DATA_WIDTH-1:0] mem [deq_pkg::DEPTH];

    logic [deq_pkg::OP_W-1:0]       op_reg;
    logic [deq_pkg::DATA_WIDTH-1:0] data_reg;
    logic [deq_pkg::PTR_W-1:0]      head_reg,  head_next;
    logic [deq_pkg::CNT_W-1:0]      count_reg, count_next;
    deq_pkg::status_t               status_reg, status_next;
    logic [deq_pkg::DATA_WIDTH-1:0] front_rd_reg, back_rd_reg;

    logic [deq_pkg::DATA_WIDTH-1:0] front_value_reg, back_value_reg;
    logic [deq_pkg::CNT_W-1:0]      occupancy_reg;
    logic                           is_empty_reg, is_full_reg;
    deq_pkg::status_t               status_out_reg;

    logic [deq_pkg::SUM_W-1:0]      tail_sum, back_sum, inc_sum;
    logic [deq_pkg::PTR_W-1:0]      tail_idx, back_idx, head_inc, head_dec;
    logic [deq_pkg::PTR_W-1:0]      waddr;
    logic                           mem_we;
    logic                           full, empty;

    assign full  = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        tail_sum = deq_pkg::SUM_W'(head_reg) + deq_pkg::SUM_W'(count_reg);
        if (tail_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
        begin
            tail_sum = tail_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH);
        end
        tail_idx = tail_sum[deq_pkg::PTR_W-1:0];

        back_sum = deq_pkg::SUM_W'(head_reg) + deq_pkg::SUM_W'(count_reg)
                   - deq_pkg::SUM_W'(1);
        if (back_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
        begin
            back_sum = back_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH);
        end
        back_idx = back_sum[deq_pkg::PTR_W-1:0];

        inc_sum = deq_pkg::SUM_W'(head_reg) + deq_pkg::SUM_W'(1);
        if (inc_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
        begin
            inc_sum = inc_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH);
        end
        head_inc = inc_sum[deq_pkg::PTR_W-1:0];

        head_dec = (head_reg == '0) ? deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)
                                    : head_reg - deq_pkg::PTR_W'(1);
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = deq_pkg::ST_DONE;
        mem_we      = 1'b0;
        waddr       = tail_idx;
        case (op_reg)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    waddr      = head_dec;
                    mem_we     = 1'b1;
                    count_next = count_reg + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - deq_pkg::CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - deq_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                status_next = deq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= deq_pkg::ST_DONE;
        end
        else if (cmd.execute)
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            data_reg <= data_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
        begin
            mem[waddr] <= data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            front_rd_reg <= mem[head_reg];
            back_rd_reg  <= mem[back_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            front_value_reg <= empty ? '1 : front_rd_reg;
            back_value_reg  <= empty ? '1 : back_rd_reg;
            occupancy_reg   <= count_reg;
            is_empty_reg    <= empty;
            is_full_reg     <= full;
            status_out_reg  <= status_reg;
        end
    end

    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign occupancy   = occupancy_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;
    assign status      = status_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(count_reg) && $stable(head_reg))
        else $error("pointer state moved without an execute");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && full
         && (op_reg == deq_pkg::OP_PUSH_FRONT || op_reg == deq_pkg::OP_PUSH_BACK))
        |=> status_reg == deq_pkg::ST_FULL && $stable(count_reg))
        else $error("push on full queue not rejected");

endmodule

`default_nettype wire

/* hdl/deq_ctrl.sv */
// Deque controller: item sequencing state machine and output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output deq_pkg::deq_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.capture    = (state_reg == S_IDLE) && in_valid;
        cmd.load       = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (cmd.load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_EXEC)
        else $error("accepted item did not start execution");

    a_exec_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_READ && !in_ready)
        else $error("execute not followed by memory read");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result load did not raise output valid");

endmodule

`default_nettype wire

/* hdl/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: controller plus datapath.
//
// Input channel: in_valid/in_ready with op (push front, push back, pop
// front, pop back, query) and data_value, the word to push.
// Output channel: out_valid/out_ready with one result per item: front and
// back words after the operation (all ones when empty), occupancy,
// is_empty, is_full and status (done, push ignored when full, pop ignored
// when empty).
// After an item is accepted, its result is formed in order by pointer
// update and memory write, memory read of front and back, and result
// register load. One item is in flight at a time and the controller is
// back in idle the cycle after the load, so a new item is accepted only
// after the previous result is loaded; the word memory has a single
// write port and a registered two-port read.
// The result register parts the channels: a new item is accepted while the
// previous result still waits; if the receiver stalls, the next item holds
// before its result load until the output register frees.
// Reset empties the queue (count and head pointer to zero); the word memory
// is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [deq_pkg::OP_W-1:0]              op,
    input  wire logic signed [deq_pkg::DATA_WIDTH-1:0] data_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [deq_pkg::DATA_WIDTH-1:0]      front_value,
    output logic signed [deq_pkg::DATA_WIDTH-1:0]      back_value,
    output logic [deq_pkg::CNT_W-1:0]                  occupancy,
    output logic                                       is_empty,
    output logic                                       is_full,
    output logic [1:0]                                 status
);

    deq_pkg::deq_cmd_t cmd;

    deq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    deq_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .data_value  (data_value),
        .front_value (front_value),
        .back_value  (back_value),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .status      (status)
    );

endmodule

`default_nettype wire
